/* src/cis_pkg.sv */
`timescale 1ns / 1ps
// package: sizes, codes, sequencer types and saturating Q-format helpers
package cis_pkg;

    localparam int BODY_COUNT    = 256;
    localparam int CONTACT_COUNT = 1024;
    localparam int FRAC_BITS     = 16;
    localparam int BWORDS        = 6;
    localparam int CWORDS        = 13;
    localparam int BODY_DEPTH    = BODY_COUNT * BWORDS;
    localparam int CONTACT_DEPTH = CONTACT_COUNT * CWORDS;
    localparam int BA_W          = $clog2(BODY_DEPTH);
    localparam int CA_W          = $clog2(CONTACT_DEPTH);

    localparam logic [2:0] OP_BODY_WR = 3'd0;
    localparam logic [2:0] OP_CONT_WR = 3'd1;
    localparam logic [2:0] OP_SOLVE   = 3'd2;
    localparam logic [2:0] OP_WARM    = 3'd3;
    localparam logic [2:0] OP_BODY_RD = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_BRDW, S_CRD, S_CHK, S_BRD, S_SQM, S_SQRT,
        S_EXEC, S_WRB, S_WRC, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        K_NOP, K_MUL, K_ADD, K_SUB, K_PASS, K_CLAMP0, K_MIN, K_MAX
    } kind_t;

    typedef enum logic [4:0] {
        D_NONE, D_T0, D_T1, D_T2, D_T3, D_T4, D_T5, D_T6, D_T7, D_T8,
        D_C11, D_C12, D_A0, D_A1, D_A2, D_B0, D_B1, D_B2
    } dst_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] s;
        s = 64'(a) + 64'(b);
        return sat32(s);
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] s;
        s = 64'(a) - 64'(b);
        return sat32(s);
    endfunction

    // arithmetic shift rounds toward minus infinity
    function automatic logic signed [31:0] qmul_fin(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p >>> FRAC_BITS;
        return sat32(s);
    endfunction

endpackage

/* src/cis_if.sv */
`timescale 1ns / 1ps
// request and response channel interfaces
interface cis_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic [9:0]         slot;
    logic [3:0]         word;
    logic signed [31:0] value;
    modport source (output valid, opcode, slot, word, value, input ready);
    modport sink (input valid, opcode, slot, word, value, output ready);
endinterface

interface cis_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] read_data;
    logic signed [31:0] normal_step;
    logic signed [31:0] tangent_step;
    logic               bad_access;
    modport source (output valid, read_data, normal_step, tangent_step, bad_access,
                    input ready);
    modport sink (input valid, read_data, normal_step, tangent_step, bad_access,
                  output ready);
endinterface

/* src/contact_impulse_solver_core.sv */
`timescale 1ns / 1ps
// contact impulse solver top level: sequencer, body and contact memories, shared alu
// One word in, one word out. Body and contact words sit in two single-port
// synchronous memories (one access a cycle, read data in the next cycle); a
// sequencer reads the entry, works it through one shared 32x32 multiplier /
// saturating adder, and writes back. Write and invalid words pass through
// accept, decode and output; a body read adds a wait for the read data. A
// warm start runs accept, decode, 14 contact reads, a range check, 13 body
// reads, 28 alu steps, 6 body writes and the output step. A solve adds a
// multiply and a bit-serial square root for the friction coefficient, 32
// more alu steps and 2 contact writes. A bad stored body index ends a solve
// or warm start at the range check. The next word is taken while the
// previous response still waits in the output register.
module contact_impulse_solver_core
    import cis_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    cis_req_if.sink      req,
    cis_rsp_if.source    rsp
);

    localparam logic [5:0] WARM_STEP = 6'd32;
    localparam logic [5:0] EXEC_LAST = 6'd59;

    state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;

    logic [2:0]         op_reg;
    logic [9:0]         slot_reg;
    logic [3:0]         word_reg;
    logic signed [31:0] value_reg;
    logic               res_bad_reg;
    logic signed [31:0] res_rd_reg;

    logic signed [31:0] c_reg [0:CWORDS-1];
    logic signed [31:0] a_reg [0:BWORDS-1];
    logic signed [31:0] b_reg [0:BWORDS-1];
    logic signed [31:0] t_reg [0:8];
    logic [63:0]        sq_rem_reg, sq_root_reg, sq_bit_reg;

    logic signed [31:0] rd_out_reg, n_out_reg, t_out_reg;
    logic               bad_out_reg;

    logic signed [31:0] bmem [0:BODY_DEPTH-1];
    logic signed [31:0] cmem [0:CONTACT_DEPTH-1];
    logic signed [31:0] bm_rdata, cm_rdata;
    logic               bm_we, cm_we;
    logic [BA_W-1:0]    bm_addr;
    logic [CA_W-1:0]    cm_addr;
    logic signed [31:0] bm_wdata, cm_wdata;

    kind_t              kind;
    dst_t               dst;
    logic signed [31:0] alu_a, alu_b, alu_res, mu;
    logic signed [63:0] prod;
    logic               dec_bad, body_bad, same_body, out_load;
    logic [63:0]        sq_trial;
    logic [5:0]         cnt_m1, cnt_m7, cnt_m3;

    // memories
    always_ff @(posedge clk)
    begin
        if (bm_we)
            bmem[bm_addr] <= bm_wdata;
        bm_rdata <= bmem[bm_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cm_we)
            cmem[cm_addr] <= cm_wdata;
        cm_rdata <= cmem[cm_addr];
    end

    assign cnt_m1 = cnt_reg - 6'd1;
    assign cnt_m7 = cnt_reg - 6'd7;
    assign cnt_m3 = cnt_reg - 6'd3;

    always_comb
    begin
        case (op_reg)
            OP_BODY_WR, OP_BODY_RD:
                dec_bad = ({22'd0, slot_reg} >= 32'(BODY_COUNT)) ||
                          ({28'd0, word_reg} >= 32'(BWORDS));
            OP_CONT_WR:
                dec_bad = ({22'd0, slot_reg} >= 32'(CONTACT_COUNT)) ||
                          ({28'd0, word_reg} >= 32'(CWORDS));
            OP_SOLVE, OP_WARM:
                dec_bad = ({22'd0, slot_reg} >= 32'(CONTACT_COUNT));
            default:
                dec_bad = 1'b1;
        endcase
    end

    assign body_bad  = ($unsigned(c_reg[0]) >= 32'(BODY_COUNT)) ||
                       ($unsigned(c_reg[1]) >= 32'(BODY_COUNT));
    assign same_body = (c_reg[0] == c_reg[1]);
    assign mu        = (sq_root_reg > 64'h7FFFFFFF) ? 32'sh7FFFFFFF
                                                    : sq_root_reg[31:0];
    assign sq_trial  = sq_root_reg + sq_bit_reg;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || rsp.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (req.valid)
                    state_next = S_DEC;
            S_DEC:
                if (dec_bad)
                    state_next = S_OUT;
                else if (op_reg == OP_BODY_RD)
                    state_next = S_BRDW;
                else if (op_reg == OP_SOLVE || op_reg == OP_WARM)
                    state_next = S_CRD;
                else
                    state_next = S_OUT;
            S_BRDW:
                state_next = S_OUT;
            S_CRD:
                if (cnt_reg == 6'(CWORDS))
                    state_next = S_CHK;
            S_CHK:
                state_next = body_bad ? S_OUT : S_BRD;
            S_BRD:
                if (cnt_reg == 6'(2 * BWORDS))
                    state_next = (op_reg == OP_SOLVE) ? S_SQM : S_EXEC;
            S_SQM:
                state_next = S_SQRT;
            S_SQRT:
                if (cnt_reg == 6'd31)
                    state_next = S_EXEC;
            S_EXEC:
                if (cnt_reg == EXEC_LAST)
                    state_next = S_WRB;
            S_WRB:
                if (cnt_reg == 6'd5)
                    state_next = (op_reg == OP_SOLVE) ? S_WRC : S_OUT;
            S_WRC:
                if (cnt_reg == 6'd1)
                    state_next = S_OUT;
            S_OUT:
                if (out_load)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (state_next != state_reg)
            cnt_next = (state_next == S_EXEC && op_reg == OP_WARM) ? WARM_STEP : 6'd0;
        else
            cnt_next = cnt_reg + 6'd1;
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // memory control
    always_comb
    begin
        bm_we    = 1'b0;
        cm_we    = 1'b0;
        bm_addr  = BA_W'({22'd0, slot_reg} * 32'(BWORDS) + {28'd0, word_reg});
        cm_addr  = CA_W'({22'd0, slot_reg} * 32'(CWORDS) + {28'd0, word_reg});
        bm_wdata = value_reg;
        cm_wdata = value_reg;
        case (state_reg)
            S_DEC:
            begin
                bm_we = !dec_bad && (op_reg == OP_BODY_WR);
                cm_we = !dec_bad && (op_reg == OP_CONT_WR);
            end
            S_CRD:
                cm_addr = CA_W'({22'd0, slot_reg} * 32'(CWORDS) + {26'd0, cnt_reg});
            S_BRD:
                if (cnt_reg < 6'(BWORDS))
                    bm_addr = BA_W'(c_reg[0] * 32'(BWORDS) + {26'd0, cnt_reg});
                else
                    bm_addr = BA_W'(c_reg[1] * 32'(BWORDS) + {26'd0, cnt_reg - 6'(BWORDS)});
            S_WRB:
            begin
                bm_we = 1'b1;
                if (cnt_reg < 6'd3)
                begin
                    bm_addr  = BA_W'(c_reg[0] * 32'(BWORDS) + {26'd0, cnt_reg});
                    bm_wdata = a_reg[cnt_reg[2:0]];
                end
                else
                begin
                    bm_addr  = BA_W'(c_reg[1] * 32'(BWORDS) + {26'd0, cnt_m3});
                    bm_wdata = b_reg[cnt_m3[2:0]];
                end
            end
            S_WRC:
            begin
                cm_we    = 1'b1;
                cm_addr  = CA_W'({22'd0, slot_reg} * 32'(CWORDS) + 32'd11 + {26'd0, cnt_reg});
                cm_wdata = cnt_reg[0] ? c_reg[12] : c_reg[11];
            end
            default:
            begin
                bm_we = 1'b0;
                cm_we = 1'b0;
            end
        endcase
    end

    // step program: one alu operation per step
    always_comb
    begin
        kind  = K_NOP;
        dst   = D_NONE;
        alu_a = '0;
        alu_b = '0;
        if (state_reg == S_SQM)
        begin
            alu_a = a_reg[5][31] ? 32'sd0 : a_reg[5];
            alu_b = b_reg[5][31] ? 32'sd0 : b_reg[5];
        end
        else if (state_reg == S_EXEC)
        begin
            case (cnt_reg)
                // relative velocity at the contact
                6'd0:  begin kind = K_MUL; alu_a = b_reg[2]; alu_b = c_reg[7]; dst = D_T0; end
                6'd1:  begin kind = K_SUB; alu_a = b_reg[0]; alu_b = t_reg[0]; dst = D_T0; end
                6'd2:  begin kind = K_MUL; alu_a = b_reg[2]; alu_b = c_reg[6]; dst = D_T1; end
                6'd3:  begin kind = K_ADD; alu_a = b_reg[1]; alu_b = t_reg[1]; dst = D_T1; end
                6'd4:  begin kind = K_MUL; alu_a = a_reg[2]; alu_b = c_reg[5]; dst = D_T2; end
                6'd5:  begin kind = K_SUB; alu_a = a_reg[0]; alu_b = t_reg[2]; dst = D_T2; end
                6'd6:  begin kind = K_MUL; alu_a = a_reg[2]; alu_b = c_reg[4]; dst = D_T3; end
                6'd7:  begin kind = K_ADD; alu_a = a_reg[1]; alu_b = t_reg[3]; dst = D_T3; end
                6'd8:  begin kind = K_SUB; alu_a = t_reg[0]; alu_b = t_reg[2]; dst = D_T0; end
                6'd9:  begin kind = K_SUB; alu_a = t_reg[1]; alu_b = t_reg[3]; dst = D_T1; end
                6'd10: begin kind = K_SUB; alu_a = '0;       alu_b = c_reg[2]; dst = D_T4; end
                6'd11: begin kind = K_MUL; alu_a = t_reg[0]; alu_b = c_reg[2]; dst = D_T2; end
                6'd12: begin kind = K_MUL; alu_a = t_reg[1]; alu_b = c_reg[3]; dst = D_T3; end
                6'd13: begin kind = K_ADD; alu_a = t_reg[2]; alu_b = t_reg[3]; dst = D_T2; end
                6'd14: begin kind = K_MUL; alu_a = t_reg[0]; alu_b = c_reg[3]; dst = D_T3; end
                6'd15: begin kind = K_MUL; alu_a = t_reg[1]; alu_b = t_reg[4]; dst = D_T5; end
                6'd16: begin kind = K_ADD; alu_a = t_reg[3]; alu_b = t_reg[5]; dst = D_T3; end
                // normal impulse, clamped at zero
                6'd17: begin kind = K_SUB; alu_a = c_reg[8]; alu_b = t_reg[2]; dst = D_T2; end
                6'd18: begin kind = K_MUL; alu_a = t_reg[2]; alu_b = c_reg[9]; dst = D_T2; end
                6'd19: begin kind = K_ADD; alu_a = c_reg[11]; alu_b = t_reg[2]; dst = D_T2; end
                6'd20: begin kind = K_CLAMP0; alu_a = t_reg[2]; dst = D_T2; end
                6'd21: begin kind = K_SUB; alu_a = t_reg[2]; alu_b = c_reg[11]; dst = D_T6; end
                // friction impulse, clamped to the cone
                6'd22: begin kind = K_SUB; alu_a = '0;       alu_b = t_reg[3]; dst = D_T3; end
                6'd23: begin kind = K_MUL; alu_a = t_reg[3]; alu_b = c_reg[10]; dst = D_T3; end
                6'd24: begin kind = K_MUL; alu_a = mu;       alu_b = t_reg[2]; dst = D_T5; end
                6'd25: begin kind = K_ADD; alu_a = c_reg[12]; alu_b = t_reg[3]; dst = D_T3; end
                6'd26: begin kind = K_MIN; alu_a = t_reg[3]; alu_b = t_reg[5]; dst = D_T3; end
                6'd27: begin kind = K_SUB; alu_a = '0;       alu_b = t_reg[5]; dst = D_T7; end
                6'd28: begin kind = K_MAX; alu_a = t_reg[3]; alu_b = t_reg[7]; dst = D_T3; end
                6'd29: begin kind = K_SUB; alu_a = t_reg[3]; alu_b = c_reg[12]; dst = D_T7; end
                6'd30: begin kind = K_PASS; alu_a = t_reg[2]; dst = D_C11; end
                6'd31: begin kind = K_PASS; alu_a = t_reg[3]; dst = D_C12; end
                // impulse vector from t6 (normal) and t7 (tangent)
                6'd32: begin kind = K_SUB; alu_a = '0;       alu_b = c_reg[2]; dst = D_T4; end
                6'd33: begin kind = K_MUL; alu_a = t_reg[6]; alu_b = c_reg[2]; dst = D_T0; end
                6'd34: begin kind = K_MUL; alu_a = t_reg[7]; alu_b = c_reg[3]; dst = D_T1; end
                6'd35: begin kind = K_ADD; alu_a = t_reg[0]; alu_b = t_reg[1]; dst = D_T0; end
                6'd36: begin kind = K_MUL; alu_a = t_reg[6]; alu_b = c_reg[3]; dst = D_T1; end
                6'd37: begin kind = K_MUL; alu_a = t_reg[7]; alu_b = t_reg[4]; dst = D_T2; end
                6'd38: begin kind = K_ADD; alu_a = t_reg[1]; alu_b = t_reg[2]; dst = D_T1; end
                // body a takes the impulse negated
                6'd39: begin kind = K_MUL; alu_a = t_reg[0]; alu_b = a_reg[3]; dst = D_T2; end
                6'd40: begin kind = K_MUL; alu_a = t_reg[1]; alu_b = a_reg[3]; dst = D_T3; end
                6'd41: begin kind = K_MUL; alu_a = c_reg[4]; alu_b = t_reg[1]; dst = D_T5; end
                6'd42: begin kind = K_MUL; alu_a = c_reg[5]; alu_b = t_reg[0]; dst = D_T8; end
                6'd43: begin kind = K_SUB; alu_a = t_reg[5]; alu_b = t_reg[8]; dst = D_T5; end
                6'd44: begin kind = K_MUL; alu_a = a_reg[4]; alu_b = t_reg[5]; dst = D_T5; end
                6'd45: begin kind = K_SUB; alu_a = a_reg[0]; alu_b = t_reg[2]; dst = D_A0; end
                6'd46: begin kind = K_SUB; alu_a = a_reg[1]; alu_b = t_reg[3]; dst = D_A1; end
                6'd47: begin kind = K_SUB; alu_a = a_reg[2]; alu_b = t_reg[5]; dst = D_A2; end
                // one body on both sides: b starts from a's update
                6'd48: begin kind = K_PASS; alu_a = a_reg[0]; dst = same_body ? D_B0 : D_NONE; end
                6'd49: begin kind = K_PASS; alu_a = a_reg[1]; dst = same_body ? D_B1 : D_NONE; end
                6'd50: begin kind = K_PASS; alu_a = a_reg[2]; dst = same_body ? D_B2 : D_NONE; end
                6'd51: begin kind = K_MUL; alu_a = t_reg[0]; alu_b = b_reg[3]; dst = D_T2; end
                6'd52: begin kind = K_MUL; alu_a = t_reg[1]; alu_b = b_reg[3]; dst = D_T3; end
                6'd53: begin kind = K_MUL; alu_a = c_reg[6]; alu_b = t_reg[1]; dst = D_T5; end
                6'd54: begin kind = K_MUL; alu_a = c_reg[7]; alu_b = t_reg[0]; dst = D_T8; end
                6'd55: begin kind = K_SUB; alu_a = t_reg[5]; alu_b = t_reg[8]; dst = D_T5; end
                6'd56: begin kind = K_MUL; alu_a = b_reg[4]; alu_b = t_reg[5]; dst = D_T5; end
                6'd57: begin kind = K_ADD; alu_a = b_reg[0]; alu_b = t_reg[2]; dst = D_B0; end
                6'd58: begin kind = K_ADD; alu_a = b_reg[1]; alu_b = t_reg[3]; dst = D_B1; end
                6'd59: begin kind = K_ADD; alu_a = b_reg[2]; alu_b = t_reg[5]; dst = D_B2; end
                default:
                begin
                    kind = K_NOP;
                    dst  = D_NONE;
                end
            endcase
        end
    end

    assign prod = alu_a * alu_b;

    always_comb
    begin
        case (kind)
            K_MUL:    alu_res = qmul_fin(prod);
            K_ADD:    alu_res = qadd(alu_a, alu_b);
            K_SUB:    alu_res = qsub(alu_a, alu_b);
            K_PASS:   alu_res = alu_a;
            K_CLAMP0: alu_res = alu_a[31] ? 32'sd0 : alu_a;
            K_MIN:    alu_res = (alu_a > alu_b) ? alu_b : alu_a;
            K_MAX:    alu_res = (alu_a < alu_b) ? alu_b : alu_a;
            default:  alu_res = '0;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req.valid)
        begin
            op_reg      <= req.opcode;
            slot_reg    <= req.slot;
            word_reg    <= req.word;
            value_reg   <= req.value;
            res_bad_reg <= 1'b0;
            res_rd_reg  <= '0;
        end
        case (state_reg)
            S_DEC:
                res_bad_reg <= dec_bad;
            S_BRDW:
                res_rd_reg <= bm_rdata;
            S_CRD:
                if (cnt_reg != 6'd0)
                    c_reg[cnt_m1[3:0]] <= cm_rdata;
            S_CHK:
                res_bad_reg <= body_bad;
            S_BRD:
            begin
                if (cnt_reg != 6'd0 && cnt_reg <= 6'(BWORDS))
                    a_reg[cnt_m1[2:0]] <= bm_rdata;
                else if (cnt_reg > 6'(BWORDS))
                    b_reg[cnt_m7[2:0]] <= bm_rdata;
                // warm start works from the stored impulses
                if (cnt_reg == 6'(2 * BWORDS))
                begin
                    t_reg[6] <= c_reg[11];
                    t_reg[7] <= c_reg[12];
                end
            end
            S_SQM:
            begin
                sq_rem_reg  <= prod;
                sq_root_reg <= '0;
                sq_bit_reg  <= 64'd1 << 62;
            end
            S_SQRT:
            begin
                if (sq_rem_reg >= sq_trial)
                begin
                    sq_rem_reg  <= sq_rem_reg - sq_trial;
                    sq_root_reg <= (sq_root_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_root_reg <= sq_root_reg >> 1;
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            S_EXEC:
            begin
                case (dst)
                    D_T0:  t_reg[0]  <= alu_res;
                    D_T1:  t_reg[1]  <= alu_res;
                    D_T2:  t_reg[2]  <= alu_res;
                    D_T3:  t_reg[3]  <= alu_res;
                    D_T4:  t_reg[4]  <= alu_res;
                    D_T5:  t_reg[5]  <= alu_res;
                    D_T6:  t_reg[6]  <= alu_res;
                    D_T7:  t_reg[7]  <= alu_res;
                    D_T8:  t_reg[8]  <= alu_res;
                    D_C11: c_reg[11] <= alu_res;
                    D_C12: c_reg[12] <= alu_res;
                    D_A0:  a_reg[0]  <= alu_res;
                    D_A1:  a_reg[1]  <= alu_res;
                    D_A2:  a_reg[2]  <= alu_res;
                    D_B0:  b_reg[0]  <= alu_res;
                    D_B1:  b_reg[1]  <= alu_res;
                    D_B2:  b_reg[2]  <= alu_res;
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (out_load)
        begin
            rd_out_reg  <= res_rd_reg;
            bad_out_reg <= res_bad_reg;
            n_out_reg   <= (op_reg == OP_SOLVE && !res_bad_reg) ? t_reg[6] : 32'sd0;
            t_out_reg   <= (op_reg == OP_SOLVE && !res_bad_reg) ? t_reg[7] : 32'sd0;
        end
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.read_data    = rd_out_reg;
    assign rsp.normal_step  = n_out_reg;
    assign rsp.tangent_step = t_out_reg;
    assign rsp.bad_access   = bad_out_reg;

endmodule

/* tb/sv/tb_contact_impulse_solver_core.sv */
`timescale 1ns / 1ps
// testbench for the contact impulse solver: directed and random words against a predictor
module tb_contact_impulse_solver_core;
    import cis_pkg::*;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic signed [31:0] normal_step;
        logic signed [31:0] tangent_step;
        logic               bad_access;
    } result_t;

    localparam int NB = 8;    // bodies used by random traffic
    localparam int NC = 12;   // contacts used by random traffic

    logic clk;
    logic rst_n;

    cis_req_if req ();
    cis_rsp_if rsp ();

    contact_impulse_solver_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    logic signed [31:0] body_mem [BODY_DEPTH];
    logic signed [31:0] contact_mem [CONTACT_DEPTH];
    result_t            expected_q [$];
    int                 error_count;
    int                 result_count;
    bit                 stall_enable;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #50ms;
        $display("tb_contact_impulse_solver_core failed");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [63:0] s;
        p = 64'(a) * 64'(b);
        s = p >>> FRAC_BITS;
        if (s > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (s < -64'sd2147483648)
            return 32'sh80000000;
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] q_sum(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input bit minus);
        logic signed [63:0] s;
        s = minus ? 64'(a) - 64'(b) : 64'(a) + 64'(b);
        if (s > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (s < -64'sd2147483648)
            return 32'sh80000000;
        return s[31:0];
    endfunction

    // floor(sqrt(a*b)) with both factors clamped at zero
    function automatic logic signed [31:0] friction_coef(input logic signed [31:0] a,
                                                         input logic signed [31:0] b);
        logic [63:0] x;
        logic [63:0] root;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        x = 64'(a < 0 ? 0 : a) * 64'(b < 0 ? 0 : b);
        lo = 0;
        hi = 64'd4294967296;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= x)
                lo = mid;
            else
                hi = mid;
        end
        root = lo;
        return root > 64'h7FFFFFFF ? 32'sh7FFFFFFF : root[31:0];
    endfunction

    function automatic void apply_impulse(input int k, input bit minus,
                                          input logic signed [31:0] rx,
                                          input logic signed [31:0] ry,
                                          input logic signed [31:0] px,
                                          input logic signed [31:0] py);
        logic signed [31:0] dvx;
        logic signed [31:0] dvy;
        logic signed [31:0] dw;
        dvx = q_mul(px, body_mem[k*BWORDS+3]);
        dvy = q_mul(py, body_mem[k*BWORDS+3]);
        dw = q_mul(body_mem[k*BWORDS+4], q_sum(q_mul(rx, py), q_mul(ry, px), 1));
        body_mem[k*BWORDS+0] = q_sum(body_mem[k*BWORDS+0], dvx, minus);
        body_mem[k*BWORDS+1] = q_sum(body_mem[k*BWORDS+1], dvy, minus);
        body_mem[k*BWORDS+2] = q_sum(body_mem[k*BWORDS+2], dw, minus);
    endfunction

    function automatic result_t predict_word(input logic [2:0] op, input int slot,
                                             input int wsel,
                                             input logic signed [31:0] value);
        result_t r;
        int cb;
        int ia;
        int ib;
        logic signed [31:0] nx, ny, tx, ty, dn, dt, px, py;
        logic signed [31:0] rbx, rby, rax, ray, dvx, dvy, vn, vt, mu, pn, pt, lim;
        r = '0;
        if (op == OP_BODY_WR || op == OP_BODY_RD)
        begin
            if (slot >= BODY_COUNT || wsel >= BWORDS)
                r.bad_access = 1'b1;
            else if (op == OP_BODY_WR)
                body_mem[slot*BWORDS+wsel] = value;
            else
                r.read_data = body_mem[slot*BWORDS+wsel];
        end
        else if (op == OP_CONT_WR)
        begin
            if (slot >= CONTACT_COUNT || wsel >= CWORDS)
                r.bad_access = 1'b1;
            else
                contact_mem[slot*CWORDS+wsel] = value;
        end
        else if (op == OP_SOLVE || op == OP_WARM)
        begin
            cb = slot * CWORDS;
            if (slot >= CONTACT_COUNT || $unsigned(contact_mem[cb]) >= BODY_COUNT
                || $unsigned(contact_mem[cb+1]) >= BODY_COUNT)
                r.bad_access = 1'b1;
            else
            begin
                ia = contact_mem[cb];
                ib = contact_mem[cb+1];
                nx = contact_mem[cb+2];
                ny = contact_mem[cb+3];
                tx = ny;
                ty = q_sum(0, nx, 1);
                if (op == OP_SOLVE)
                begin
                    rbx = q_sum(body_mem[ib*BWORDS], q_mul(body_mem[ib*BWORDS+2],
                                contact_mem[cb+7]), 1);
                    rby = q_sum(body_mem[ib*BWORDS+1], q_mul(body_mem[ib*BWORDS+2],
                                contact_mem[cb+6]), 0);
                    rax = q_sum(body_mem[ia*BWORDS], q_mul(body_mem[ia*BWORDS+2],
                                contact_mem[cb+5]), 1);
                    ray = q_sum(body_mem[ia*BWORDS+1], q_mul(body_mem[ia*BWORDS+2],
                                contact_mem[cb+4]), 0);
                    dvx = q_sum(rbx, rax, 1);
                    dvy = q_sum(rby, ray, 1);
                    vn = q_sum(q_mul(dvx, nx), q_mul(dvy, ny), 0);
                    vt = q_sum(q_mul(dvx, tx), q_mul(dvy, ty), 0);
                    mu = friction_coef(body_mem[ia*BWORDS+5], body_mem[ib*BWORDS+5]);
                    dn = q_mul(q_sum(contact_mem[cb+8], vn, 1), contact_mem[cb+9]);
                    pn = q_sum(contact_mem[cb+11], dn, 0);
                    if (pn < 0)
                        pn = 0;
                    dn = q_sum(pn, contact_mem[cb+11], 1);
                    dt = q_mul(q_sum(0, vt, 1), contact_mem[cb+10]);
                    lim = q_mul(mu, pn);
                    pt = q_sum(contact_mem[cb+12], dt, 0);
                    if (pt > lim)
                        pt = lim;
                    if (pt < -lim)
                        pt = -lim;
                    dt = q_sum(pt, contact_mem[cb+12], 1);
                    contact_mem[cb+11] = pn;
                    contact_mem[cb+12] = pt;
                    r.normal_step = dn;
                    r.tangent_step = dt;
                end
                else
                begin
                    dn = contact_mem[cb+11];
                    dt = contact_mem[cb+12];
                end
                px = q_sum(q_mul(dn, nx), q_mul(dt, tx), 0);
                py = q_sum(q_mul(dn, ny), q_mul(dt, ty), 0);
                apply_impulse(ia, 1, contact_mem[cb+4], contact_mem[cb+5], px, py);
                apply_impulse(ib, 0, contact_mem[cb+6], contact_mem[cb+7], px, py);
            end
        end
        else
            r.bad_access = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
    endtask

    // valid stays high when the next word follows with no gap
    task automatic send_word(input logic [2:0] op, input int slot, input int wsel,
                             input logic signed [31:0] value);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            req.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        expected_q.push_back(predict_word(op, slot, wsel, value));
        req.valid <= 1'b1;
        req.opcode <= op;
        req.slot <= slot[9:0];
        req.word <= wsel[3:0];
        req.value <= value;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    // response checker with random back pressure while stall_enable is set
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                result_count++;
                if (expected_q.size() == 0)
                    report_mismatch("unexpected word", rsp.read_data, 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.read_data !== want.read_data)
                        report_mismatch("read_data", rsp.read_data, want.read_data);
                    if (rsp.normal_step !== want.normal_step)
                        report_mismatch("normal_step", rsp.normal_step, want.normal_step);
                    if (rsp.tangent_step !== want.tangent_step)
                        report_mismatch("tangent_step", rsp.tangent_step,
                                        want.tangent_step);
                    if (rsp.bad_access !== want.bad_access)
                        report_mismatch("bad_access", rsp.bad_access, want.bad_access);
                end
            end
            rsp.ready <= stall_enable ? ($urandom_range(0, 99) < 65) : 1'b1;
        end
    end

    function automatic logic signed [31:0] small_q();
        // mostly moderate magnitudes, some full range
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endfunction

    task automatic load_body(input int k, input bit wild);
        int w;
        for (w = 0; w < BWORDS; w++)
            send_word(OP_BODY_WR, k, w, wild ? $urandom : small_q());
    endtask

    task automatic load_contact(input int c, input int a, input int b, input bit wild);
        int w;
        send_word(OP_CONT_WR, c, 0, a);
        send_word(OP_CONT_WR, c, 1, b);
        for (w = 2; w < CWORDS; w++)
            send_word(OP_CONT_WR, c, w, wild ? $urandom : small_q());
    endtask

    task automatic test_directed();
        load_body(0, 0);
        load_body(BODY_COUNT - 1, 1);
        send_word(OP_BODY_WR, 1, 0, 32'sh7FFFFFFF);
        send_word(OP_BODY_RD, 1, 0, 0);
        send_word(OP_BODY_RD, BODY_COUNT - 1, 5, 0);
        send_word(OP_BODY_WR, BODY_COUNT, 0, 5);
        send_word(OP_BODY_RD, 2, BWORDS, 0);
        send_word(OP_CONT_WR, 3, CWORDS, 0);
        send_word(OP_CONT_WR, 1023, 15, 32'sh80000000);
        send_word(3'd5, 0, 0, 0);
        send_word(3'd7, 1023, 15, -1);
        // stored body index out of range
        load_contact(5, 0, 0, 0);
        send_word(OP_CONT_WR, 5, 0, 32'sh80000000);
        send_word(OP_SOLVE, 5, 0, 0);
        send_word(OP_WARM, 5, 9, 0);
        load_contact(1023, 0, 0, 0);
        send_word(OP_CONT_WR, 1023, 1, BODY_COUNT);
        send_word(OP_WARM, 1023, 0, 0);
    endtask

    task automatic test_same_body();
        load_contact(0, 0, 0, 0);
        send_word(OP_SOLVE, 0, 0, 0);
        send_word(OP_WARM, 0, 0, 0);
        send_word(OP_BODY_RD, 0, 2, 0);
    endtask

    task automatic test_extremes();
        load_contact(1, BODY_COUNT - 1, 0, 1);
        send_word(OP_SOLVE, 1, 0, 0);
        send_word(OP_WARM, 1, 0, 0);
        send_word(OP_BODY_RD, BODY_COUNT - 1, 1, 0);
    endtask

    task automatic test_random(input int count);
        int n;
        int r;
        int k;
        for (k = 0; k < NB; k++)
            load_body(k, 0);
        for (k = 0; k < NC; k++)
            load_contact(k, $urandom_range(0, NB - 1), $urandom_range(0, NB - 1), 0);
        n = 0;
        while (n < count)
        begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, NC - 1);
            if (r < 40)
                send_word(OP_SOLVE, k, $urandom_range(0, 15), $urandom);
            else if (r < 50)
                send_word(OP_WARM, k, $urandom_range(0, 15), $urandom);
            else if (r < 62)
                send_word(OP_BODY_RD, $urandom_range(0, NB - 1), $urandom_range(0, 5), 0);
            else if (r < 72)
                send_word(OP_BODY_WR, $urandom_range(0, NB - 1), $urandom_range(0, 5),
                          $urandom_range(0, 3) == 0 ? $urandom : small_q());
            else if (r < 82)
                send_word(OP_CONT_WR, k, $urandom_range(2, 12),
                          $urandom_range(0, 3) == 0 ? $urandom : small_q());
            else if (r < 86)
                send_word(OP_CONT_WR, k, $urandom_range(0, 1), $urandom_range(0, NB - 1));
            else if (r < 94)
                send_word(OP_BODY_WR, $urandom_range(BODY_COUNT, 1023),
                          $urandom_range(0, 15), $urandom);
            else if (r < 97)
                send_word(3'($urandom_range(5, 7)), $urandom_range(0, 1023),
                          $urandom_range(0, 15), $urandom);
            else
                send_word(OP_CONT_WR, $urandom_range(0, 1023), $urandom_range(13, 15),
                          $urandom);
            n++;
            if (n % 200 == 100)
                stall_enable = ~stall_enable;
        end
    endtask

    initial
    begin
        int wait_cycles;
        error_count = 0;
        result_count = 0;
        stall_enable = 1'b1;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.opcode = '0;
        req.slot = '0;
        req.word = '0;
        req.value = '0;
        rsp.ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_same_body();
        test_extremes();
        test_random(640);
        req.valid <= 1'b0;
        wait_cycles = 0;
        while (expected_q.size() != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (200) @(posedge clk);
        if (error_count == 0 && expected_q.size() == 0)
            $display("tb_contact_impulse_solver_core passed");
        else
            $display("tb_contact_impulse_solver_core failed");
        $finish;
    end
endmodule
